### hw/rtl/gne_pkg.sv
// Shared types and constants for the 2D gradient noise evaluator.
`timescale 1ns / 1ps
package gne_pkg;

   localparam logic [1:0] ACT_PERM = 2'd0;
   localparam logic [1:0] ACT_GRAD = 2'd1;
   localparam logic [1:0] ACT_EVAL = 2'd2;

   localparam logic [19:0] FADE_C15 = 20'd983040;
   localparam logic [19:0] FADE_C10 = 20'd655360;
   localparam logic [19:0] FADE_C6  = 20'd6;

   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  index;
      logic        in_range;
      logic [15:0] grad_x;
      logic [15:0] grad_y;
   } item_type;

endpackage

### hw/rtl/gne_mod.sv
// Two-stage constant modulo unit: reciprocal multiply, then one correction step.
`timescale 1ns / 1ps
module gne_mod #(
   parameter int W = 17,
   parameter int M = 128
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [W-1:0]         val,
   output logic [$clog2(M)-1:0] rem
);
   localparam int IW = $clog2(M);
   localparam int PW = 2 * W;
   localparam int DW = W + 10;
   localparam longint RECIP = ((longint'(1) << W) + longint'(M) - 1) / longint'(M);

   logic [PW-1:0] prod;
   logic [W-1:0]  val_ff;
   logic [W-1:0]  quo_ff;
   logic [DW-1:0] qm;
   logic [DW-1:0] diff;
   logic [DW-1:0] fix;
   logic [IW-1:0] rem_ff;

   assign prod = PW'(val) * PW'(RECIP);
   assign qm   = DW'(quo_ff) * DW'(M);
   assign diff = DW'(val_ff) - qm;
   assign fix  = diff[DW-1] ? diff + DW'(M) : diff;

   always_ff @(posedge clock) begin
      if (enable) begin
         val_ff <= val;
         quo_ff <= prod[PW-1:W];
         rem_ff <= fix[IW-1:0];
      end
   end

   assign rem = rem_ff;
endmodule

### hw/rtl/gne_fade.sv
// Three-stage quintic fade 6t^5-15t^4+10t^3 on a Q0.16 fraction.
`timescale 1ns / 1ps
module gne_fade (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] frac,
   output logic [16:0] fade
);
   logic [19:0] a;
   logic [19:0] t15;
   logic [35:0] cp;
   logic [31:0] u2p;
   logic [19:0] c_ff;
   logic [15:0] u2_ff;
   logic [15:0] u1_ff;
   logic [19:0] d;
   logic [31:0] u3p;
   logic [19:0] d_ff;
   logic [15:0] u3_ff;
   logic [35:0] sp;
   logic [16:0] s_ff;

   assign a   = 20'(frac) * gne_pkg::FADE_C6;
   assign t15 = gne_pkg::FADE_C15 - a;
   assign cp  = 36'(frac) * 36'(t15);
   assign u2p = 32'(frac) * 32'(frac);
   assign d   = gne_pkg::FADE_C10 - c_ff;
   assign u3p = 32'(u2_ff) * 32'(u1_ff);
   assign sp  = 36'(u3_ff) * 36'(d_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         c_ff  <= cp[35:16];
         u2_ff <= u2p[31:16];
         u1_ff <= frac;
         d_ff  <= d;
         u3_ff <= u3p[31:16];
         s_ff  <= sp[32:16];
      end
   end

   assign fade = s_ff;
endmodule

### hw/rtl/gne_lerp.sv
// Registered linear interpolation a + round((b-a)*s / 2^16), s in Q1.16.
`timescale 1ns / 1ps
module gne_lerp #(
   parameter int NW = 34
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic signed [NW-1:0] a,
   input  logic signed [NW-1:0] b,
   input  logic [16:0]          s,
   output logic signed [NW-1:0] y
);
   localparam int PW = NW + 19;

   logic signed [NW:0]   diff;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rnd;
   logic signed [NW-1:0] y_ff;

   assign diff = (NW+1)'(b) - (NW+1)'(a);
   assign prod = PW'(diff) * $signed({{(PW-17){1'b0}}, s});
   assign rnd  = (prod + PW'(32768)) >>> 16;

   always_ff @(posedge clock) begin
      if (enable) begin
         y_ff <= a + rnd[NW-1:0];
      end
   end

   assign y = y_ff;
endmodule

### hw/rtl/gradient_noise_2d_eval.sv
// Top level of the 2D gradient noise evaluator.
// An accepted evaluate transaction passes the valid registers vld_ff[1:6] and ev_ff[7:10] before rsp_valid.
// Throughput: one transaction per cycle; the whole pipeline holds while rsp_valid waits.
// Loads give no response and write the table copies as they pass each lookup stage.
// Reset clears the valid bits only; tables stay undefined until written.
`timescale 1ns / 1ps
module gradient_noise_2d_eval #(
   parameter int TABLE_SIZE      = 128,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [6:0]         req_table_index,
   input  logic [6:0]         req_perm_value,
   input  logic signed [15:0] req_grad_x,
   input  logic signed [15:0] req_grad_y,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_noise_value
);
   localparam int FB  = COORD_FRAC_BITS;
   localparam int IW  = $clog2(TABLE_SIZE);
   localparam int CW  = 32 - FB;
   localparam int MW  = CW + 1;
   localparam int OFF = TABLE_SIZE * (((1 << (CW - 1)) + TABLE_SIZE - 1) / TABLE_SIZE);

   logic                 adv;
   logic [6:1]           vld_ff;
   logic [10:7]          ev_ff;
   logic                 rsp_valid_ff;
   logic signed [15:0]   rsp_noise_ff;
   gne_pkg::item_type    it_in;
   gne_pkg::item_type    it_ff [1:6];
   logic [6:0]           perm_ff;
   logic [31:0]          cx_ff;
   logic [31:0]          cy_ff;
   logic [15:0]          ux;
   logic [15:0]          vy;
   logic [MW-1:0]        valx;
   logic [MW-1:0]        valy;
   logic [15:0]          u_ff [2:7];
   logic [15:0]          v_ff [2:7];
   logic [IW-1:0]        ii3;
   logic [IW-1:0]        cjm3;
   logic [IW-1:0]        pm3;
   logic [IW-1:0]        cjm4_ff;
   logic [IW-1:0]        pm4_ff;
   logic [IW-1:0]        pm5_ff;
   logic [IW-1:0]        pa0_ff;
   logic [IW-1:0]        pa1_ff;
   logic [IW:0]          sum0;
   logic [IW:0]          sum1;
   logic [IW-1:0]        mj5_ff;
   logic [IW-1:0]        mj15_ff;
   logic [IW-1:0]        e00_ff;
   logic [IW-1:0]        e01_ff;
   logic [IW-1:0]        e10_ff;
   logic [IW-1:0]        e11_ff;
   logic [31:0]          g00_ff;
   logic [31:0]          g01_ff;
   logic [31:0]          g10_ff;
   logic [31:0]          g11_ff;
   logic signed [33:0]   n00_ff;
   logic signed [33:0]   n01_ff;
   logic signed [33:0]   n10_ff;
   logic signed [33:0]   n11_ff;
   logic [16:0]          sx4;
   logic [16:0]          sy4;
   logic [16:0]          sx_ff [5:8];
   logic [16:0]          sy_ff [5:9];
   logic signed [33:0]   x0;
   logic signed [33:0]   x1;
   logic signed [33:0]   r31;
   logic signed [33:0]   rr;
   logic signed [17:0]   rsh;
   logic signed [15:0]   noise_in;
   logic                 wr_a;
   logic                 wr_bc;
   logic                 wr_g;
   logic [IW-1:0]        pa_mem [TABLE_SIZE];
   logic [IW-1:0]        pb_mem [TABLE_SIZE];
   logic [IW-1:0]        pc_mem [TABLE_SIZE];
   logic [31:0]          gt0_mem [TABLE_SIZE];
   logic [31:0]          gt1_mem [TABLE_SIZE];

   function automatic logic [IW-1:0] nxt(input logic [IW-1:0] k);
      return (k == IW'(TABLE_SIZE - 1)) ? '0 : k + IW'(1);
   endfunction

   function automatic logic signed [33:0] dot(input logic [15:0] u, input logic [15:0] v,
                                              input logic ux1, input logic vy1,
                                              input logic [31:0] g);
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      dx = $signed({2'b00, u}) - (ux1 ? 18'sd65536 : 18'sd0);
      dy = $signed({2'b00, v}) - (vy1 ? 18'sd65536 : 18'sd0);
      return 34'(dx) * 34'($signed(g[15:0])) + 34'(dy) * 34'($signed(g[31:16]));
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      it_in.action   = req_action;
      it_in.index    = req_table_index;
      it_in.in_range = ({2'b00, req_table_index} < 9'(TABLE_SIZE));
      it_in.grad_x   = req_grad_x;
      it_in.grad_y   = req_grad_y;
   end

   // stage 1 split: floor cell (offset to a positive multiple of the table size) and fraction
   assign valx = {cx_ff[31], cx_ff[31:FB]} + MW'(OFF);
   assign valy = {cy_ff[31], cy_ff[31:FB]} + MW'(OFF);

   generate
      if (FB >= 16) begin : g_frac_cut
         assign ux = cx_ff[FB-1 -: 16];
         assign vy = cy_ff[FB-1 -: 16];
      end else begin : g_frac_pad
         assign ux = {cx_ff[FB-1:0], {(16-FB){1'b0}}};
         assign vy = {cy_ff[FB-1:0], {(16-FB){1'b0}}};
      end
   endgenerate

   gne_mod #(.W(MW), .M(TABLE_SIZE)) u_mod_x (
      .clock(clock), .enable(adv), .val(valx), .rem(ii3)
   );
   gne_mod #(.W(MW), .M(TABLE_SIZE)) u_mod_y (
      .clock(clock), .enable(adv), .val(valy), .rem(cjm3)
   );
   gne_mod #(.W(7), .M(TABLE_SIZE)) u_mod_p (
      .clock(clock), .enable(adv), .val(perm_ff), .rem(pm3)
   );
   gne_fade u_fade_x (.clock(clock), .enable(adv), .frac(ux), .fade(sx4));
   gne_fade u_fade_y (.clock(clock), .enable(adv), .frac(vy), .fade(sy4));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ev_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[1]    <= req_valid;
         vld_ff[6:2]  <= vld_ff[5:1];
         ev_ff[7]     <= vld_ff[6] && (it_ff[6].action == gne_pkg::ACT_EVAL);
         ev_ff[10:8]  <= ev_ff[9:7];
         rsp_valid_ff <= ev_ff[10];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff[1] <= it_in;
         for (int k = 2; k <= 6; k++) begin
            it_ff[k] <= it_ff[k-1];
         end
         perm_ff <= req_perm_value;
         cx_ff   <= req_coord_x;
         cy_ff   <= req_coord_y;
         u_ff[2] <= ux;
         v_ff[2] <= vy;
         for (int k = 3; k <= 7; k++) begin
            u_ff[k] <= u_ff[k-1];
            v_ff[k] <= v_ff[k-1];
         end
         sx_ff[5] <= sx4;
         sy_ff[5] <= sy4;
         for (int k = 6; k <= 8; k++) begin
            sx_ff[k] <= sx_ff[k-1];
         end
         for (int k = 6; k <= 9; k++) begin
            sy_ff[k] <= sy_ff[k-1];
         end
         cjm4_ff <= cjm3;
         pm4_ff  <= pm3;
         pm5_ff  <= pm4_ff;
         mj5_ff  <= (sum0 >= (IW+1)'(TABLE_SIZE)) ? IW'(sum0 - (IW+1)'(TABLE_SIZE)) : IW'(sum0);
         mj15_ff <= (sum1 >= (IW+1)'(TABLE_SIZE)) ? IW'(sum1 - (IW+1)'(TABLE_SIZE)) : IW'(sum1);
         n00_ff  <= dot(u_ff[7], v_ff[7], 1'b0, 1'b0, g00_ff);
         n01_ff  <= dot(u_ff[7], v_ff[7], 1'b0, 1'b1, g01_ff);
         n10_ff  <= dot(u_ff[7], v_ff[7], 1'b1, 1'b0, g10_ff);
         n11_ff  <= dot(u_ff[7], v_ff[7], 1'b1, 1'b1, g11_ff);
         rsp_noise_ff <= noise_in;
      end
   end

   assign sum0 = (IW+1)'(pa0_ff) + (IW+1)'(cjm4_ff);
   assign sum1 = (IW+1)'(pa1_ff) + (IW+1)'(cjm4_ff);

   assign wr_a  = vld_ff[3] && (it_ff[3].action == gne_pkg::ACT_PERM) && it_ff[3].in_range;
   assign wr_bc = vld_ff[5] && (it_ff[5].action == gne_pkg::ACT_PERM) && it_ff[5].in_range;
   assign wr_g  = vld_ff[6] && (it_ff[6].action == gne_pkg::ACT_GRAD) && it_ff[6].in_range;

   // row hash lookup
   always_ff @(posedge clock) begin
      if (adv) begin
         if (wr_a) begin
            pa_mem[IW'(it_ff[3].index)] <= pm3;
         end
         pa0_ff <= pa_mem[ii3];
         pa1_ff <= pa_mem[nxt(ii3)];
      end
   end

   // corner hash lookups
   always_ff @(posedge clock) begin
      if (adv) begin
         if (wr_bc) begin
            pb_mem[IW'(it_ff[5].index)] <= pm5_ff;
            pc_mem[IW'(it_ff[5].index)] <= pm5_ff;
         end
         e00_ff <= pb_mem[mj5_ff];
         e01_ff <= pb_mem[nxt(mj5_ff)];
         e10_ff <= pc_mem[mj15_ff];
         e11_ff <= pc_mem[nxt(mj15_ff)];
      end
   end

   // gradient lookups
   always_ff @(posedge clock) begin
      if (adv) begin
         if (wr_g) begin
            gt0_mem[IW'(it_ff[6].index)] <= {it_ff[6].grad_y, it_ff[6].grad_x};
            gt1_mem[IW'(it_ff[6].index)] <= {it_ff[6].grad_y, it_ff[6].grad_x};
         end
         g00_ff <= gt0_mem[e00_ff];
         g01_ff <= gt0_mem[e01_ff];
         g10_ff <= gt1_mem[e10_ff];
         g11_ff <= gt1_mem[e11_ff];
      end
   end

   gne_lerp #(.NW(34)) u_lerp_x0 (
      .clock(clock), .enable(adv), .a(n00_ff), .b(n10_ff), .s(sx_ff[8]), .y(x0)
   );
   gne_lerp #(.NW(34)) u_lerp_x1 (
      .clock(clock), .enable(adv), .a(n01_ff), .b(n11_ff), .s(sx_ff[8]), .y(x1)
   );
   gne_lerp #(.NW(34)) u_lerp_y (
      .clock(clock), .enable(adv), .a(x0), .b(x1), .s(sy_ff[9]), .y(r31)
   );

   assign rr  = r31 + 34'sd32768;
   assign rsh = 18'(rr >>> 16);

   always_comb begin
      if (rsh > 18'sd32767) begin
         noise_in = 16'sh7fff;
      end else if (rsh < -18'sd32768) begin
         noise_in = 16'sh8000;
      end else begin
         noise_in = rsh[15:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;
endmodule
